[hdl/dtst_pkg.sv]
package dtst_pkg;

  // Request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_FETCH  = 2'd2;

  // Register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int GRID_SHIFT_DEF = 7;
  localparam logic [14:0] FRAME_SIZE_RST = 15'd1024;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] corner_a_x;
    logic [14:0] corner_a_y;
    logic [14:0] corner_b_x;
    logic [14:0] corner_b_y;
  } req_t;

  typedef struct packed {
    logic        strip_found;
    logic [14:0] draw_x;
    logic [14:0] draw_y;
    logic [15:0] draw_w;
    logic [15:0] draw_h;
    logic        scan_done;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SET,
    ST_INS_RD,
    ST_INS_WR,
    ST_F_ROW,
    ST_F_LOAD,
    ST_F_SCAN,
    ST_F_RUN,
    ST_M_ROW,
    ST_M_LOAD,
    ST_M_CNT,
    ST_EMIT,
    ST_CLIP,
    ST_RESP
  } state_t;

  // Tile shift picked from a frame dimension
  function automatic logic [3:0] tile_shift(logic [14:0] size);
    logic [3:0] sh;
    if (size <= 15'd1024) sh = 4'd3;
    else if (size <= 15'd2048) sh = 4'd4;
    else if (size <= 15'd4096) sh = 4'd5;
    else if (size <= 15'd8192) sh = 4'd6;
    else if (size <= 15'd16384) sh = 4'd7;
    else sh = 4'd8;
    return sh;
  endfunction

endpackage

[hdl/dtst_map.sv]
module dtst_map import dtst_pkg::*; #(
  parameter int GRID_SHIFT = GRID_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       wr_en,
  input  logic [GRID_SHIFT-1:0]      wr_addr,
  input  logic [(1<<GRID_SHIFT)-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [GRID_SHIFT-1:0]      rd_addr,
  output logic [(1<<GRID_SHIFT)-1:0] rd_data
);

  localparam int DIM = 1 << GRID_SHIFT;

  // One word per tile row
  logic [DIM-1:0] mem [DIM];
  logic [DIM-1:0] row_vld;
  logic [DIM-1:0] rd_q;
  logic           vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Row valid bits: a row never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      row_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= row_vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? rd_q : '0;

endmodule

[hdl/dirty_tile_strip_tracker.sv]
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-----------------------------
// request   | req_valid / req_ready     | req (req_t)
// result    | res_valid / res_ready     | res (res_t)
// config    | cfg_we                    | cfg_index, cfg_data
//
// Insert reads each tile row of the box, then writes it back with the row mask OR-ed in.
// Fetch reads each box row it visits and steps the row scan one tile column per cycle;
// the merge reads each row it tries and walks its run one column per cycle, all through
// the one read port of the row memory.
// Reset (sync, active high) and clear empty the map at once via row valid bits.
// A new request is taken while a finished result still waits in the output reg.
module dirty_tile_strip_tracker import dtst_pkg::*; #(
  parameter int GRID_SHIFT = GRID_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int DIM = 1 << GRID_SHIFT;
  localparam int GW  = GRID_SHIFT;
  localparam int GW1 = GRID_SHIFT + 1;
  localparam int PW  = (GRID_SHIFT + 10 > 17) ? GRID_SHIFT + 10 : 17;
  localparam logic [14:0] TILE_MAX = 15'(DIM - 1);

  state_t state, state_next;

  logic [14:0] frame_width, frame_height;
  logic [3:0]  shift_x, shift_y;

  logic          box_valid;
  logic [GW-1:0] box_left, box_top, box_right, box_bottom;
  logic          scan_active;
  logic [GW1-1:0] scan_row, scan_col;

  req_t           req_q;
  res_t           res_d;
  logic [GW-1:0]  ins_row, ins_end;
  logic [DIM-1:0] ins_mask;
  logic [DIM-1:0] row_buf;
  logic [GW1-1:0] cur_c;
  logic [GW-1:0]  run_start;
  logic [GW1-1:0] run_end;
  logic [GW1-1:0] mrow;
  logic [GW1-1:0] unset;
  logic [GW1-1:0] height;
  logic [PW-1:0]  px, py, pw, ph;

  logic           map_clr, map_wr_en, map_rd_en;
  logic [GW-1:0]  map_wr_addr, map_rd_addr;
  logic [DIM-1:0] map_wr_data, map_rd_data;

  logic [GW1-1:0] run_w;
  logic [GW1:0]   thr;
  logic [GW-1:0]  tx1, tx2, ty1, ty2, xlo, xhi, ylo, yhi;
  logic           res_load;
  logic           col_in;
  logic [PW-1:0]  clip_w, clip_h;

  // Pixel coordinate to tile index with saturation
  function automatic logic [GRID_SHIFT-1:0] to_tile(logic [14:0] coord, logic [14:0] size,
                                                    logic [3:0] sh);
    logic [14:0] lim, c, t;
    lim = (size == 15'd0) ? 15'd0 : size - 15'd1;
    c   = (coord > lim) ? lim : coord;
    t   = c >> sh;
    return (t > TILE_MAX) ? TILE_MAX[GRID_SHIFT-1:0] : t[GRID_SHIFT-1:0];
  endfunction

  // Clip a length to the frame
  function automatic logic [PW-1:0] clip_len(logic [PW-1:0] pos, logic [PW-1:0] len,
                                             logic [14:0] size);
    logic [PW-1:0] sz, r;
    sz = PW'(size);
    if (pos > sz) r = '0;
    else if (len != '0 && (pos + len - PW'(1)) > sz) r = sz - pos + PW'(1);
    else r = len;
    return r;
  endfunction

  dtst_map #(.GRID_SHIFT(GRID_SHIFT)) u_map (
    .clk     (clk),
    .rst     (rst),
    .clr     (map_clr),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  // Corner ordering for insert
  assign tx1 = to_tile(req_q.corner_a_x, frame_width, shift_x);
  assign tx2 = to_tile(req_q.corner_b_x, frame_width, shift_x);
  assign ty1 = to_tile(req_q.corner_a_y, frame_height, shift_y);
  assign ty2 = to_tile(req_q.corner_b_y, frame_height, shift_y);
  assign xlo = (tx2 < tx1) ? tx2 : tx1;
  assign xhi = (tx2 < tx1) ? tx1 : tx2;
  assign ylo = (ty2 < ty1) ? ty2 : ty1;
  assign yhi = (ty2 < ty1) ? ty1 : ty2;

  assign run_w   = run_end - {1'b0, run_start};
  assign thr     = ({1'b0, run_w} + (GW1+1)'(1)) >> 2;
  assign col_in  = cur_c <= {1'b0, box_right};
  assign clip_w  = clip_len(px, pw, frame_width);
  assign clip_h  = clip_len(py, ph, frame_height);
  assign res_load = (state == ST_RESP) && (!res_valid || res_ready);
  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and map port control
  always_comb begin
    state_next  = state;
    map_wr_en   = 1'b0;
    map_wr_addr = '0;
    map_wr_data = row_buf;
    map_rd_en   = 1'b0;
    map_rd_addr = '0;
    map_clr     = cfg_we;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.req_type)
            REQ_CLEAR: begin
              map_clr    = 1'b1;
              state_next = ST_RESP;
            end
            REQ_INSERT: state_next = ST_INS_SET;
            REQ_FETCH: begin
              state_next = (!scan_active && !box_valid) ? ST_RESP : ST_F_ROW;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_INS_SET: state_next = ST_INS_RD;
      ST_INS_RD: begin
        map_rd_en   = 1'b1;
        map_rd_addr = ins_row;
        state_next  = ST_INS_WR;
      end
      ST_INS_WR: begin
        map_wr_en   = 1'b1;
        map_wr_addr = ins_row;
        map_wr_data = map_rd_data | ins_mask;
        state_next  = (ins_row == ins_end) ? ST_RESP : ST_INS_RD;
      end
      ST_F_ROW: begin
        if (scan_row <= {1'b0, box_bottom}) begin
          map_rd_en   = 1'b1;
          map_rd_addr = scan_row[GW-1:0];
          state_next  = ST_F_LOAD;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_F_LOAD: state_next = ST_F_SCAN;
      ST_F_SCAN: begin
        if (!col_in) state_next = ST_F_ROW;
        else if (row_buf[cur_c[GW-1:0]]) state_next = ST_F_RUN;
      end
      ST_F_RUN: begin
        if (!(col_in && row_buf[cur_c[GW-1:0]])) begin
          map_wr_en   = 1'b1;
          map_wr_addr = scan_row[GW-1:0];
          state_next  = ST_M_ROW;
        end
      end
      ST_M_ROW: begin
        if (mrow <= {1'b0, box_bottom}) begin
          map_rd_en   = 1'b1;
          map_rd_addr = mrow[GW-1:0];
          state_next  = ST_M_LOAD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_M_LOAD: state_next = ST_M_CNT;
      ST_M_CNT: begin
        if (cur_c >= run_end) begin
          if (thr < {1'b0, unset}) begin
            state_next = ST_EMIT;
          end else begin
            map_wr_en   = 1'b1;
            map_wr_addr = mrow[GW-1:0];
            state_next  = ST_M_ROW;
          end
        end
      end
      ST_EMIT: state_next = ST_CLIP;
      ST_CLIP: state_next = ST_RESP;
      ST_RESP: begin
        if (!res_valid || res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Tracker state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_SIZE_RST;
      frame_height <= FRAME_SIZE_RST;
      shift_x      <= tile_shift(FRAME_SIZE_RST);
      shift_y      <= tile_shift(FRAME_SIZE_RST);
      box_valid    <= 1'b0;
      scan_active  <= 1'b0;
      scan_row     <= '0;
      scan_col     <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
        res       <= res_d;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) begin
          frame_width <= cfg_data;
          shift_x     <= tile_shift(cfg_data);
        end else begin
          frame_height <= cfg_data;
          shift_y      <= tile_shift(cfg_data);
        end
        box_valid   <= 1'b0;
        scan_active <= 1'b0;
        scan_row    <= '0;
        scan_col    <= '0;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            // empty-box fetch answers done at once; scan_done is the low bit
            res_d <= {{($bits(res_t)-1){1'b0}},
                      (req.req_type == REQ_FETCH) && !scan_active && !box_valid};
            if (req.req_type == REQ_CLEAR) begin
              box_valid   <= 1'b0;
              scan_active <= 1'b0;
              scan_row    <= '0;
              scan_col    <= '0;
            end else if (req.req_type == REQ_FETCH && !scan_active) begin
              if (box_valid) begin
                scan_active <= 1'b1;
                scan_row    <= {1'b0, box_top};
                scan_col    <= {1'b0, box_left};
              end
            end
          end
        end
        ST_INS_SET: begin
          box_valid  <= 1'b1;
          box_left   <= (!box_valid || xlo < box_left) ? xlo : box_left;
          box_right  <= (!box_valid || xhi > box_right) ? xhi : box_right;
          box_top    <= (!box_valid || ylo < box_top) ? ylo : box_top;
          box_bottom <= (!box_valid || yhi > box_bottom) ? yhi : box_bottom;
          ins_row    <= ylo;
          ins_end    <= yhi;
          ins_mask   <= ({DIM{1'b1}} << xlo) & ({DIM{1'b1}} >> (TILE_MAX[GW-1:0] - xhi));
        end
        ST_INS_WR: begin
          ins_row <= ins_row + GW'(1);
        end
        ST_F_ROW: begin
          if (scan_row <= {1'b0, box_bottom}) begin
            if (scan_col < {1'b0, box_left}) scan_col <= {1'b0, box_left};
          end else begin
            scan_active     <= 1'b0;
            scan_row        <= '0;
            scan_col        <= '0;
            box_valid       <= 1'b0;
            res_d.scan_done <= 1'b1;
          end
        end
        ST_F_LOAD: begin
          row_buf <= map_rd_data;
          cur_c   <= scan_col;
        end
        ST_F_SCAN: begin
          if (col_in) begin
            if (row_buf[cur_c[GW-1:0]]) run_start <= cur_c[GW-1:0];
            else cur_c <= cur_c + GW1'(1);
          end else begin
            scan_row <= scan_row + GW1'(1);
            scan_col <= {1'b0, box_left};
          end
        end
        ST_F_RUN: begin
          if (col_in && row_buf[cur_c[GW-1:0]]) begin
            row_buf[cur_c[GW-1:0]] <= 1'b0;
            cur_c <= cur_c + GW1'(1);
          end else begin
            scan_col <= cur_c;
            run_end  <= cur_c;
            mrow     <= scan_row + GW1'(1);
            height   <= GW1'(1);
          end
        end
        ST_M_LOAD: begin
          row_buf <= map_rd_data;
          cur_c   <= {1'b0, run_start};
          unset   <= '0;
        end
        ST_M_CNT: begin
          if (cur_c < run_end) begin
            unset <= unset + GW1'(!row_buf[cur_c[GW-1:0]]);
            row_buf[cur_c[GW-1:0]] <= 1'b0;
            cur_c <= cur_c + GW1'(1);
          end else if (!(thr < {1'b0, unset})) begin
            height <= height + GW1'(1);
            mrow   <= mrow + GW1'(1);
          end
        end
        ST_EMIT: begin
          px <= PW'(run_start) << shift_x;
          pw <= PW'(run_w) << shift_x;
          py <= PW'(scan_row) << shift_y;
          ph <= PW'(height) << shift_y;
        end
        ST_CLIP: begin
          res_d.strip_found <= 1'b1;
          res_d.draw_x      <= px[14:0];
          res_d.draw_y      <= py[14:0];
          res_d.draw_w      <= clip_w[15:0];
          res_d.draw_h      <= clip_h[15:0];
          res_d.scan_done   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_scan_needs_box: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> box_valid) else $error("scan active with empty box");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box_left <= box_right && box_top <= box_bottom))
    else $error("bounding box corners out of order");

  a_resp_loads: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid) else $error("finished result not presented");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_d.scan_done) |=> !box_valid)
    else $error("done result with box still set");
`endif

endmodule
